// ----- src/flcd_pkg.sv -----
// ----------------------------------------------------------------------------
// flcd_pkg
// shared types and codes of the cache directory
// ----------------------------------------------------------------------------
`default_nettype none
package flcd_pkg;

	localparam int unsigned SLOT_W   = 10;
	localparam int unsigned S_DATA_W = 112;
	localparam int unsigned M_DATA_W = 24;
	localparam int unsigned KEY_W    = 80;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	localparam logic MODE_FIFO = 1'b0;
	localparam logic MODE_LRU  = 1'b1;

	localparam logic [1:0] REG_REPLACE_MODE    = 2'd0;
	localparam logic [1:0] REG_CAPACITY        = 2'd1;
	localparam logic [1:0] REG_MAX_OBJECT_SIZE = 2'd2;

	// request word payload, key_tag in the lowest bits
	typedef struct packed {
		logic [31:0] object_size;
		logic [15:0] request_port;
		logic [63:0] key_tag;
	} flcd_cmd_t;

	// response word payload, hit in the lowest bit
	typedef struct packed {
		logic              rejected;
		logic [SLOT_W-1:0] evicted_slot;
		logic              evicted;
		logic [SLOT_W-1:0] slot;
		logic              hit;
	} flcd_res_t;

endpackage
`default_nettype wire

// ----- src/fifo_lru_cache_directory_top.sv -----
// ----------------------------------------------------------------------------
// fifo_lru_cache_directory_top
// fully associative cache directory with fifo or lru replacement
// ----------------------------------------------------------------------------
// A request word (lookup or insert of a 64-bit tag plus 16-bit port) is taken
// when s_tready is high and produces exactly one response word. Every request
// makes one pass over all MAX_ENTRIES slots through a single read port of the
// key and rank stores, a decision step, and, when ranks change (lru hit or a
// newly written entry), a second read-modify-write pass over the rank store,
// then the result is loaded into the output register; no new request is taken
// until then, so the passes through the store port bound the request rate.
// Ranks are 0 for the newest or most recently used entry; the largest rank is
// the victim. After reset the valid/rank store is cleared one slot a cycle and
// no request is taken until it is done; register writes are taken always. The
// response sits in an output register, so the next request may enter while
// the previous response still waits to be taken; a further response stalls
// until that register is free.
`default_nettype none
module fifo_lru_cache_directory_top #(
	parameter int unsigned MAX_ENTRIES = 1024
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// request stream
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [111:0]  s_tdata,   // key_tag, request_port, object_size
	input  wire logic [0:0]    s_tuser,   // command
	// response stream
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [23:0]        m_tdata,   // hit, slot, evicted, evicted_slot, rejected, pad
	// register writes
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [31:0]   cfg_wdata
);
	import flcd_pkg::*;

	// slot index width and count width (count must hold MAX_ENTRIES itself)
	localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

	logic        replace_mode_q;
	logic [10:0] capacity_q;
	logic [31:0] max_object_size_q;

	flcd_cmd_t   in_cmd;
	flcd_res_t   out_res;

	logic [IW-1:0]    raddr;
	logic             tag_we;
	logic [IW-1:0]    tag_waddr;
	logic [KEY_W-1:0] tag_wdata;
	logic [KEY_W-1:0] tag_rdata;
	logic             rv_we;
	logic [IW-1:0]    rv_waddr;
	logic [IW:0]      rv_wdata;
	logic [IW:0]      rv_rdata;

	// configuration registers, out-of-range index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replace_mode_q    <= MODE_FIFO;
			capacity_q        <= '0;
			max_object_size_q <= 32'd1048576;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REPLACE_MODE:    replace_mode_q    <= cfg_wdata[0];
				REG_CAPACITY:        capacity_q        <= cfg_wdata[10:0];
				REG_MAX_OBJECT_SIZE: max_object_size_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign in_cmd  = flcd_cmd_t'(s_tdata);
	assign m_tdata = {1'b0, out_res};

	// sequencer with the scan and update passes
	flcd_ctrl #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.IW          (IW),
		.CW          (CW)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.in_cmd          (in_cmd),
		.in_command      (s_tuser[0]),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_res         (out_res),
		.replace_mode    (replace_mode_q),
		.capacity        (capacity_q),
		.max_object_size (max_object_size_q),
		.raddr           (raddr),
		.tag_we          (tag_we),
		.tag_waddr       (tag_waddr),
		.tag_wdata       (tag_wdata),
		.tag_rdata       (tag_rdata),
		.rv_we           (rv_we),
		.rv_waddr        (rv_waddr),
		.rv_wdata        (rv_wdata),
		.rv_rdata        (rv_rdata)
	);

	// key store and valid/rank store
	flcd_mem #(
		.DEPTH (MAX_ENTRIES),
		.IW    (IW)
	) u_mem (
		.clk       (clk),
		.raddr     (raddr),
		.tag_we    (tag_we),
		.tag_waddr (tag_waddr),
		.tag_wdata (tag_wdata),
		.tag_rdata (tag_rdata),
		.rv_we     (rv_we),
		.rv_waddr  (rv_waddr),
		.rv_wdata  (rv_wdata),
		.rv_rdata  (rv_rdata)
	);

endmodule
`default_nettype wire

// ----- src/flcd_mem.sv -----
// ----------------------------------------------------------------------------
// flcd_mem
// key store and valid/rank store, one write and one registered read each
// ----------------------------------------------------------------------------
`default_nettype none
module flcd_mem #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned IW    = 10
) (
	input  wire logic                     clk,
	input  wire logic [IW-1:0]            raddr,
	input  wire logic                     tag_we,
	input  wire logic [IW-1:0]            tag_waddr,
	input  wire logic [flcd_pkg::KEY_W-1:0] tag_wdata,
	output logic [flcd_pkg::KEY_W-1:0]      tag_rdata,
	input  wire logic                     rv_we,
	input  wire logic [IW-1:0]            rv_waddr,
	input  wire logic [IW:0]              rv_wdata,
	output logic [IW:0]                   rv_rdata
);
	import flcd_pkg::*;

	logic [KEY_W-1:0] tag_mem [DEPTH];
	logic [IW:0]      rv_mem  [DEPTH];

	always_ff @(posedge clk) begin
		if (tag_we) begin
			tag_mem[tag_waddr] <= tag_wdata;
		end
		tag_rdata <= tag_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (rv_we) begin
			rv_mem[rv_waddr] <= rv_wdata;
		end
		rv_rdata <= rv_mem[raddr];
	end

endmodule
`default_nettype wire

// ----- src/flcd_ctrl.sv -----
// ----------------------------------------------------------------------------
// flcd_ctrl
// sequencer: clear pass, key scan, decision, rank update pass, result register
// ----------------------------------------------------------------------------
`default_nettype none
module flcd_ctrl #(
	parameter int unsigned MAX_ENTRIES = 1024,
	parameter int unsigned IW          = 10,
	parameter int unsigned CW          = 11
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire flcd_pkg::flcd_cmd_t      in_cmd,
	input  wire logic                     in_command,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output flcd_pkg::flcd_res_t           out_res,
	input  wire logic                     replace_mode,
	input  wire logic [10:0]              capacity,
	input  wire logic [31:0]              max_object_size,
	output logic [IW-1:0]                 raddr,
	output logic                          tag_we,
	output logic [IW-1:0]                 tag_waddr,
	output logic [flcd_pkg::KEY_W-1:0]    tag_wdata,
	input  wire logic [flcd_pkg::KEY_W-1:0] tag_rdata,
	output logic                          rv_we,
	output logic [IW-1:0]                 rv_waddr,
	output logic [IW:0]                   rv_wdata,
	input  wire logic [IW:0]              rv_rdata
);
	import flcd_pkg::*;

	localparam logic [IW-1:0] LAST = IW'(MAX_ENTRIES - 1);

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_SCAN, ST_SFLUSH, ST_DECIDE, ST_UPD, ST_UFLUSH, ST_DONE
	} state_t;

	state_t         state_q;
	logic [IW-1:0]  cnt_q;
	logic           rd_v_s1;
	logic [IW-1:0]  idx_s1;
	flcd_cmd_t      cmd_q;
	logic           command_q;
	logic [CW-1:0]  count_q;
	logic           match_found_q, tail_found_q, free_found_q;
	logic [IW-1:0]  match_idx_q, match_rank_q, tail_idx_q, tail_rank_q, free_idx_q;
	logic           ins_q, front_q, ev_q;
	logic [IW-1:0]  s_q, t_q, r_q;
	flcd_res_t      res_q, out_q;
	logic           out_valid_q;

	logic [CW-1:0]  cap_eff;
	logic           rd_valid;
	logic [IW-1:0]  rd_rank;
	logic           key_eq;
	logic [IW:0]    upd_wdata;
	logic           is_ins, cap_zero, dec_rej, dec_hit, dec_front, dec_new, dec_ev;
	logic           dec_write;
	logic [IW-1:0]  dec_s;
	flcd_res_t      dec_res;
	logic           in_scan, in_upd;

	always_comb begin
		if (32'(capacity) > 32'(MAX_ENTRIES)) begin
			cap_eff = CW'(MAX_ENTRIES);
		end else begin
			cap_eff = CW'(capacity);
		end
	end

	assign rd_valid = rv_rdata[IW];
	assign rd_rank  = rv_rdata[IW-1:0];
	assign key_eq   = (tag_rdata == {cmd_q.request_port, cmd_q.key_tag});
	assign in_scan  = (state_q == ST_SCAN) || (state_q == ST_SFLUSH);
	assign in_upd   = (state_q == ST_UPD) || (state_q == ST_UFLUSH);

	// per-entry rank update, the one shared step of the update pass
	always_comb begin
		upd_wdata = rv_rdata;
		if (ins_q && idx_s1 == s_q) begin
			upd_wdata = {1'b1, {IW{1'b0}}};
		end else if (ev_q && idx_s1 == t_q) begin
			upd_wdata = {1'b0, rd_rank};
		end else if (front_q && idx_s1 == s_q) begin
			upd_wdata = {1'b1, {IW{1'b0}}};
		end else if (rd_valid && (ins_q || rd_rank < r_q)) begin
			upd_wdata = {1'b1, rd_rank + IW'(1)};
		end
	end

	always_comb begin
		is_ins    = (command_q == CMD_INSERT);
		cap_zero  = (cap_eff == '0);
		dec_rej   = is_ins && (cap_zero || cmd_q.object_size > max_object_size);
		dec_hit   = !cap_zero && !dec_rej && match_found_q;
		dec_front = dec_hit && (replace_mode == MODE_LRU);
		dec_new   = is_ins && !dec_rej && !match_found_q;
		dec_ev    = dec_new && (count_q >= cap_eff) && (count_q != '0) && tail_found_q;
		if (dec_ev) begin
			dec_s = (free_found_q && free_idx_q < tail_idx_q) ? free_idx_q : tail_idx_q;
		end else begin
			dec_s = free_idx_q;
		end
		dec_write = dec_new && (dec_ev || free_found_q);
		dec_res.hit          = dec_hit;
		dec_res.slot         = dec_hit ? SLOT_W'(match_idx_q) :
		                       (dec_write ? SLOT_W'(dec_s) : '0);
		dec_res.evicted      = dec_ev;
		dec_res.evicted_slot = dec_ev ? SLOT_W'(tail_idx_q) : '0;
		dec_res.rejected     = dec_rej;
	end

	assign raddr     = cnt_q;
	assign tag_we    = (state_q == ST_DECIDE) && dec_write;
	assign tag_waddr = dec_s;
	assign tag_wdata = {cmd_q.request_port, cmd_q.key_tag};
	assign rv_we     = (state_q == ST_CLEAR) || (rd_v_s1 && in_upd);
	assign rv_waddr  = (state_q == ST_CLEAR) ? cnt_q : idx_s1;
	assign rv_wdata  = (state_q == ST_CLEAR) ? '0 : upd_wdata;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			cnt_q         <= '0;
			rd_v_s1       <= 1'b0;
			count_q       <= '0;
			match_found_q <= 1'b0;
			tail_found_q  <= 1'b0;
			free_found_q  <= 1'b0;
			ins_q         <= 1'b0;
			front_q       <= 1'b0;
			ev_q          <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == ST_SCAN) || (state_q == ST_UPD);
			idx_s1  <= cnt_q;

			// scan accumulation on the word read in the previous cycle
			if (rd_v_s1 && in_scan) begin
				if (rd_valid && key_eq && !match_found_q) begin
					match_found_q <= 1'b1;
					match_idx_q   <= idx_s1;
					match_rank_q  <= rd_rank;
				end
				if (rd_valid && (!tail_found_q || rd_rank > tail_rank_q)) begin
					tail_found_q <= 1'b1;
					tail_idx_q   <= idx_s1;
					tail_rank_q  <= rd_rank;
				end
				if (!rd_valid && !free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= idx_s1;
				end
			end

			// response taken while no new one is loaded
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_CLEAR: begin
					if (cnt_q == LAST) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + IW'(1);
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q         <= in_cmd;
						command_q     <= in_command;
						match_found_q <= 1'b0;
						tail_found_q  <= 1'b0;
						free_found_q  <= 1'b0;
						cnt_q         <= '0;
						state_q       <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cnt_q == LAST) begin
						cnt_q   <= '0;
						state_q <= ST_SFLUSH;
					end else begin
						cnt_q <= cnt_q + IW'(1);
					end
				end
				ST_SFLUSH: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					res_q   <= dec_res;
					ins_q   <= dec_write;
					front_q <= dec_front;
					ev_q    <= dec_ev;
					s_q     <= dec_front ? match_idx_q : dec_s;
					t_q     <= tail_idx_q;
					r_q     <= match_rank_q;
					count_q <= count_q - CW'(dec_ev) + CW'(dec_write);
					cnt_q   <= '0;
					state_q <= (dec_front || dec_write) ? ST_UPD : ST_DONE;
				end
				ST_UPD: begin
					if (cnt_q == LAST) begin
						cnt_q   <= '0;
						state_q <= ST_UFLUSH;
					end else begin
						cnt_q <= cnt_q + IW'(1);
					end
				end
				ST_UFLUSH: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_q       <= res_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- tb/tb_flcd_checker.sv -----
// ----------------------------------------------------------------------------
// tb_flcd_checker
// watches the request, response and register channels, predicts each
// response from a private copy of the directory and compares field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_flcd_checker
	import flcd_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [111:0] s_tdata,
	input  wire logic [0:0]   s_tuser,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [23:0]  m_tdata,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_wdata,
	output int                errors,
	output int                pending
);

	localparam int unsigned DEPTH = 1024;

	logic [63:0]  dir_tag   [DEPTH];
	logic [15:0]  dir_port  [DEPTH];
	logic         dir_valid [DEPTH];
	int unsigned  dir_rank  [DEPTH];
	int unsigned  dir_count;

	logic         lru_mode;
	logic [10:0]  cap_reg;
	logic [31:0]  size_limit;

	flcd_res_t    responses_due[$];

	initial begin
		errors  = 0;
		pending = 0;
	end

	task automatic report(input string field, input int got, input int want);
		$display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, field, got, want);
		errors++;
	endtask

	function automatic int find_entry(logic [63:0] tag, logic [15:0] port);
		for (int i = 0; i < DEPTH; i++)
			if (dir_valid[i] && dir_tag[i] == tag && dir_port[i] == port)
				return i;
		return -1;
	endfunction

	function automatic void promote(int s);
		int unsigned r;
		r = dir_rank[s];
		for (int i = 0; i < DEPTH; i++)
			if (dir_valid[i] && dir_rank[i] < r)
				dir_rank[i]++;
		dir_rank[s] = 0;
	endfunction

	// one request against the directory copy, returns the response it causes
	function automatic flcd_res_t apply_request(logic cmd, flcd_cmd_t req);
		flcd_res_t   res;
		int unsigned cap;
		int          s;
		int          victim;
		res = '0;
		cap = (cap_reg > DEPTH) ? DEPTH : cap_reg;
		if (cmd == CMD_LOOKUP) begin
			if (cap != 0) begin
				s = find_entry(req.key_tag, req.request_port);
				if (s >= 0) begin
					res.hit  = 1'b1;
					res.slot = s[SLOT_W-1:0];
					if (lru_mode == MODE_LRU)
						promote(s);
				end
			end
		end else if (cap == 0 || req.object_size > size_limit) begin
			res.rejected = 1'b1;
		end else begin
			s = find_entry(req.key_tag, req.request_port);
			if (s >= 0) begin
				res.hit  = 1'b1;
				res.slot = s[SLOT_W-1:0];
				if (lru_mode == MODE_LRU)
					promote(s);
			end else begin
				// full (or over a lowered capacity): drop the tail once
				if (dir_count >= cap && dir_count > 0) begin
					victim = -1;
					for (int i = 0; i < DEPTH; i++)
						if (dir_valid[i] && (victim < 0 || dir_rank[i] > dir_rank[victim]))
							victim = i;
					if (victim >= 0) begin
						dir_valid[victim] = 1'b0;
						dir_count--;
						res.evicted      = 1'b1;
						res.evicted_slot = victim[SLOT_W-1:0];
					end
				end
				s = -1;
				for (int i = 0; i < DEPTH && s < 0; i++)
					if (!dir_valid[i])
						s = i;
				if (s >= 0) begin
					for (int i = 0; i < DEPTH; i++)
						if (dir_valid[i])
							dir_rank[i]++;
					dir_valid[s] = 1'b1;
					dir_tag[s]   = req.key_tag;
					dir_port[s]  = req.request_port;
					dir_rank[s]  = 0;
					dir_count++;
					res.slot = s[SLOT_W-1:0];
				end
			end
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		flcd_res_t got;
		flcd_res_t want;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				dir_valid[i] = 1'b0;
			dir_count  = 0;
			lru_mode   = MODE_FIFO;
			cap_reg    = '0;
			size_limit = 32'd1048576;
			responses_due.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_REPLACE_MODE:    lru_mode = cfg_wdata[0];
					REG_CAPACITY:        cap_reg = cfg_wdata[10:0];
					REG_MAX_OBJECT_SIZE: size_limit = cfg_wdata;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got = flcd_res_t'(m_tdata[22:0]);
				if (responses_due.size() == 0) begin
					$display("%0t: response word with none outstanding", $realtime);
					errors++;
				end else begin
					want = responses_due.pop_front();
					if (got.hit != want.hit)
						report("hit", got.hit, want.hit);
					if (got.slot != want.slot)
						report("slot", got.slot, want.slot);
					if (got.evicted != want.evicted)
						report("evicted", got.evicted, want.evicted);
					if (got.evicted_slot != want.evicted_slot)
						report("evicted_slot", got.evicted_slot, want.evicted_slot);
					if (got.rejected != want.rejected)
						report("rejected", got.rejected, want.rejected);
				end
			end
			if (s_tvalid && s_tready)
				responses_due.push_back(apply_request(s_tuser[0], flcd_cmd_t'(s_tdata)));
			pending <= responses_due.size();
		end
	end

endmodule

// ----- tb/tb_fifo_lru_cache_directory_top.sv -----
// ----------------------------------------------------------------------------
// tb_fifo_lru_cache_directory_top
// stimulus and verdict for the cache directory
// ----------------------------------------------------------------------------
// Directed words cover disabled caching, size limits at both ends, extreme
// tags and ports, refresh, eviction under a lowered capacity and a junk
// register index. Random phases then sweep mode and capacity settings with
// keys drawn mostly from a small pool so that hits, refreshes and evictions
// are frequent. The checker module predicts and compares every response.
`timescale 1ns / 1ps
module tb_fifo_lru_cache_directory_top;
	import flcd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 4000000;

	logic         clk       = 1'b0;
	logic         arst_n    = 1'b0;
	logic         s_tvalid  = 1'b0;
	logic         s_tready;
	logic [111:0] s_tdata   = '0;
	logic [0:0]   s_tuser   = '0;
	logic         m_tvalid;
	logic         m_tready  = 1'b0;
	logic [23:0]  m_tdata;
	logic         cfg_we    = 1'b0;
	logic [1:0]   cfg_index = '0;
	logic [31:0]  cfg_wdata = '0;

	int           errors;
	int           pending;
	int unsigned  cycles = 0;

	// receiver controls, set by the stimulus process
	bit           rx_steady = 1'b0;
	int           rx_hold_arm = 0;
	int           rx_hold_left = 0;

	// key pool so that random words hit what earlier words stored
	logic [63:0]  tag_pool [16];
	logic [15:0]  port_pool [4];

	always #2 clk = ~clk;

	fifo_lru_cache_directory_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	tb_flcd_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// response side: random stalls, a quiet stretch, and an armed long hold
	always @(posedge clk) begin
		if (rx_hold_arm != 0) begin
			rx_hold_left = rx_hold_arm;
			rx_hold_arm  = 0;
		end
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			m_tready <= 1'b0;
		end else if (rx_steady) begin
			m_tready <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= 30);
		end
	end

	// one request word; the sender may pause before it
	task automatic send_word(input logic cmd, input logic [63:0] tag,
			input logic [15:0] port, input logic [31:0] size);
		flcd_cmd_t req;
		if (!rx_steady && $urandom_range(99) < 30) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 2500)) @(posedge clk);
		end
		req.key_tag      = tag;
		req.request_port = port;
		req.object_size  = size;
		s_tvalid <= 1'b1;
		s_tdata  <= req;
		s_tuser  <= cmd;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// hold the sender until every outstanding response has come
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// block is idle here; upper write bits are junk the block must mask
	task automatic configure(input logic mode, input logic [10:0] cap,
			input logic [31:0] limit);
		cfg_we    <= 1'b1;
		cfg_index <= REG_REPLACE_MODE;
		cfg_wdata <= {31'($urandom()), mode};
		@(posedge clk);
		cfg_index <= REG_CAPACITY;
		cfg_wdata <= {21'($urandom_range(0, 2097151)), cap};
		@(posedge clk);
		cfg_index <= REG_MAX_OBJECT_SIZE;
		cfg_wdata <= limit;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic random_word(input logic [31:0] limit);
		logic [63:0] tag;
		logic [15:0] port;
		logic [31:0] size;
		tag  = ($urandom_range(99) < 85) ? tag_pool[$urandom_range(15)]
				: {$urandom(), $urandom()};
		port = ($urandom_range(99) < 85) ? port_pool[$urandom_range(3)]
				: 16'($urandom());
		case ($urandom_range(9))
			0:       size = limit + 32'($urandom_range(1, 1000));
			1:       size = $urandom();
			2:       size = limit;
			default: size = $urandom_range(0, 65535);
		endcase
		send_word(logic'($urandom_range(1)), tag, port, size);
	endtask

	initial begin
		logic [63:0] ones;
		ones = '1;
		for (int i = 0; i < 16; i++)
			tag_pool[i] = {$urandom(), $urandom()};
		tag_pool[0] = '0;
		tag_pool[1] = ones;
		port_pool[0] = '0;
		port_pool[1] = 16'hFFFF;
		port_pool[2] = 16'd80;
		port_pool[3] = 16'($urandom());

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// caching disabled at reset: insert refused, lookup misses
		send_word(CMD_INSERT, 64'h1234, 16'd80, 32'd10);
		send_word(CMD_LOOKUP, 64'h1234, 16'd80, 32'd10);
		wait_drained();

		// junk index is ignored; capacity above the limit saturates
		cfg_we    <= 1'b1;
		cfg_index <= 2'd3;
		cfg_wdata <= '1;
		@(posedge clk);
		cfg_we    <= 1'b0;
		configure(MODE_FIFO, 11'h7FF, 32'hFFFF_FFFF);
		send_word(CMD_INSERT, 64'h0, 16'h0, 32'hFFFF_FFFF);
		send_word(CMD_INSERT, ones, 16'hFFFF, 32'h0);
		send_word(CMD_INSERT, ones, 16'h0, 32'h5);
		send_word(CMD_LOOKUP, 64'h0, 16'h0, 32'h0);
		send_word(CMD_LOOKUP, ones, 16'hFFFF, 32'hFFFF_FFFF);
		send_word(CMD_LOOKUP, 64'h0, 16'hFFFF, 32'h0);
		send_word(CMD_INSERT, 64'h0, 16'h0, 32'h7);
		wait_drained();

		// size limit boundary, then a zero limit
		configure(MODE_FIFO, 11'd1024, 32'd100);
		send_word(CMD_INSERT, 64'hAAAA, 16'd1, 32'd101);
		send_word(CMD_INSERT, 64'hAAAA, 16'd1, 32'd100);
		wait_drained();
		configure(MODE_FIFO, 11'd1024, 32'd0);
		send_word(CMD_INSERT, 64'hBBBB, 16'd1, 32'd1);
		send_word(CMD_INSERT, 64'hBBBB, 16'd1, 32'd0);
		wait_drained();

		// capacity lowered below the count, lru reordering and eviction
		configure(MODE_LRU, 11'd2, 32'd1048576);
		send_word(CMD_LOOKUP, 64'h0, 16'h0, 32'h0);
		send_word(CMD_INSERT, 64'hC0, 16'd2, 32'd3);
		send_word(CMD_INSERT, ones, 16'hFFFF, 32'd3);
		send_word(CMD_INSERT, 64'hC1, 16'd2, 32'd3);
		send_word(CMD_LOOKUP, 64'hC0, 16'd2, 32'd3);
		send_word(CMD_INSERT, 64'hC2, 16'd2, 32'd3);
		wait_drained();

		// capacity zero with entries left: lookups miss
		configure(MODE_LRU, 11'd0, 32'd1048576);
		send_word(CMD_LOOKUP, 64'hC2, 16'd2, 32'd0);
		send_word(CMD_INSERT, 64'hC3, 16'd2, 32'd0);
		wait_drained();

		// random phases over several settings
		for (int phase = 0; phase < 9; phase++) begin
			logic        mode;
			logic [10:0] cap;
			logic [31:0] limit;
			mode  = logic'(phase % 2);
			case (phase)
				0: cap = 11'd4;
				1: cap = 11'd4;
				2: cap = 11'd8;
				3: cap = 11'd1;
				4: cap = 11'd3;
				5: cap = 11'd16;
				6: cap = 11'd1024;
				7: cap = 11'h7FF;
				default: cap = 11'd5;
			endcase
			limit = (phase == 7) ? 32'hFFFF_FFFF : 32'($urandom_range(1000, 200000));
			configure(mode, cap, limit);
			// one phase runs with no idling on either side
			rx_steady = (phase == 2);
			// hold the receiver off while requests keep coming
			if (phase == 4)
				rx_hold_arm = 7000;
			for (int n = 0; n < 30; n++)
				random_word(limit);
			wait_drained();
		end
		rx_steady = 1'b0;

		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
